[rtl/least_slack_time_scheduler_assert.svh]
// Assertion macros for the least-slack-time scheduler.
// Included by the top level; depends on nothing else.
`ifndef LEAST_SLACK_TIME_SCHEDULER_ASSERT_SVH
`define LEAST_SLACK_TIME_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsts: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsts: next-cycle check failed");

`endif

[rtl/lsts_pkg.sv]
// Shared types and constants for the least-slack-time scheduler.
// No dependencies; every other file of the block but the assertion header uses it.
`default_nettype none

package lsts_pkg;

   // Fixed field widths of the transactions.
   localparam int FIELD_W       = 16;
   localparam int SLOT_OUT_W    = 4;
   localparam int SLACK_OUT_W   = 18;
   localparam int TIME_OUT_W    = 16;
   localparam int SLACK_OUT_MAX = 131071;

   // Defaults for the top-level parameters.
   localparam int MAX_JOBS_DEF  = 16;
   localparam int TIME_BITS_DEF = 16;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FINISH,
      S_RESULT
   } state_type;

   // One job table entry as stored in memory.
   typedef struct packed {
      logic [FIELD_W-1:0] release_time;
      logic [FIELD_W-1:0] deadline;
      logic [FIELD_W-1:0] remaining;
   } job_entry_type;

   // Control from the sequencer to the minimum tracker.
   typedef struct packed {
      logic start;
      logic valid;
   } scan_ctl_type;

endpackage

`default_nettype wire

[rtl/lsts_if.sv]
// Handshake channels of the least-slack-time scheduler.
// Depends on lsts_pkg for the field widths.
`default_nettype none

interface lsts_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic [lsts_pkg::FIELD_W-1:0]     release_time;
   logic [lsts_pkg::FIELD_W-1:0]     deadline;
   logic [lsts_pkg::FIELD_W-1:0]     exec_time;

   modport source (output valid, opcode, release_time, deadline, exec_time, input ready);
   modport sink   (input valid, opcode, release_time, deadline, exec_time, output ready);
endinterface

interface lsts_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [lsts_pkg::SLOT_OUT_W-1:0]       slot;
   logic                                  idle;
   logic signed [lsts_pkg::SLACK_OUT_W-1:0] slack;
   logic [lsts_pkg::TIME_OUT_W-1:0]       current_time;
   logic                                  job_done;

   modport source (output valid, slot, idle, slack, current_time, job_done, input ready);
   modport sink   (input valid, slot, idle, slack, current_time, job_done, output ready);
endinterface

`default_nettype wire

[rtl/lsts_job_mem.sv]
// Job table memory: one write port, one read port with registered data.
// Depends on lsts_pkg for the entry type.
`default_nettype none

module lsts_job_mem #(
   parameter int DEPTH = lsts_pkg::MAX_JOBS_DEF,
   parameter int IDX_W = $clog2(lsts_pkg::MAX_JOBS_DEF)
) (
   input  wire logic                    clock,
   input  wire logic                    we,
   input  wire logic [IDX_W-1:0]        waddr,
   input  wire lsts_pkg::job_entry_type wdata,
   input  wire logic [IDX_W-1:0]        raddr,
   output lsts_pkg::job_entry_type      rdata
);

   lsts_pkg::job_entry_type mem_ff [DEPTH];
   lsts_pkg::job_entry_type rdata_ff;

   // Synchronous write and read; read data is registered.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/lsts_min_tracker.sv]
// Least-slack tracker: rates each entry read during a scan and keeps the best.
// Depends on lsts_pkg for the entry and control types.
`default_nettype none

module lsts_min_tracker #(
   parameter int TIME_BITS = lsts_pkg::TIME_BITS_DEF,
   parameter int IDX_W     = $clog2(lsts_pkg::MAX_JOBS_DEF),
   parameter int SW        = ((TIME_BITS > lsts_pkg::FIELD_W) ? TIME_BITS
                                                              : lsts_pkg::FIELD_W) + 2
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire lsts_pkg::scan_ctl_type  scan_ctl,
   input  wire logic [IDX_W-1:0]        scan_idx,
   input  wire logic [TIME_BITS-1:0]    time_now,
   input  wire lsts_pkg::job_entry_type rd_job,
   output logic                         found,
   output logic [IDX_W-1:0]             pick,
   output logic signed [SW-1:0]         best_slack,
   output lsts_pkg::job_entry_type      best_job
);

   localparam int CW = SW - 2;

   logic                    rd_valid_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    found_ff;
   logic                    found_in;
   logic [IDX_W-1:0]        pick_ff;
   logic [IDX_W-1:0]        pick_in;
   logic signed [SW-1:0]    best_ff;
   logic signed [SW-1:0]    best_in;
   lsts_pkg::job_entry_type best_job_ff;
   lsts_pkg::job_entry_type best_job_in;
   logic                    job_ready;
   logic signed [SW-1:0]    slack_cur;

   // A job is eligible when it has time left and has been released.
   assign job_ready = (rd_job.remaining != '0) &&
                      (CW'(rd_job.release_time) <= CW'(time_now));
   assign slack_cur = $signed(SW'(rd_job.deadline)) - $signed(SW'(time_now))
                      - $signed(SW'(rd_job.remaining));

   // Replace the best entry only on a strictly smaller slack, so the lowest slot wins ties.
   always_comb begin
      found_in    = found_ff;
      pick_in     = pick_ff;
      best_in     = best_ff;
      best_job_in = best_job_ff;
      if (scan_ctl.start) begin
         found_in = 1'b0;
      end else if (rd_valid_ff && job_ready && (!found_ff || slack_cur < best_ff)) begin
         found_in    = 1'b1;
         pick_in     = rd_idx_ff;
         best_in     = slack_cur;
         best_job_in = rd_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         rd_valid_ff <= scan_ctl.valid;
         found_ff    <= found_in;
      end
      rd_idx_ff   <= scan_idx;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      best_job_ff <= best_job_in;
   end

   assign found      = found_ff;
   assign pick       = pick_ff;
   assign best_slack = best_ff;
   assign best_job   = best_job_ff;

endmodule

`default_nettype wire

[rtl/least_slack_time_scheduler.sv]
// Top level of the least-slack-time scheduler: sequencer, time counter, result register.
// Depends on lsts_pkg, lsts_if, lsts_job_mem, lsts_min_tracker and the assertion header.
//
//   Channel   Direction  Transaction
//   req_ch    in         load a job or advance one tick
//   rsp_ch    out        slot, idle flag, slack, time, completion flag
//
// A load passes straight from acceptance to the result state. A tick scans the N loaded
// jobs: the single read port of the job table visits one slot a cycle, then the drain
// state takes the last read and the finish state writes back the chosen job.
// Reset is synchronous; it clears the job count, time and handshakes, not the table.
// A stalled result holds the sequencer; a new transaction is taken while a result waits.
`default_nettype none

`include "least_slack_time_scheduler_assert.svh"

module least_slack_time_scheduler #(
   parameter int MAX_JOBS  = lsts_pkg::MAX_JOBS_DEF,
   parameter int TIME_BITS = lsts_pkg::TIME_BITS_DEF
) (
   input wire logic      clock,
   input wire logic      reset,
   lsts_req_if.sink      req_ch,
   lsts_rsp_if.source    rsp_ch
);

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int SW    = ((TIME_BITS > lsts_pkg::FIELD_W) ? TIME_BITS
                                                           : lsts_pkg::FIELD_W) + 2;
   localparam int SOW   = lsts_pkg::SLACK_OUT_W;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic signed [SW-1:0] SLACK_HI = SW'(lsts_pkg::SLACK_OUT_MAX);
   localparam logic signed [SW-1:0] SLACK_LO = ~SLACK_HI;

   lsts_pkg::state_type                   state_ff, state_in;
   logic [CNT_W-1:0]                      job_count_ff, job_count_in;
   logic [TIME_BITS-1:0]                  time_ff, time_in;
   logic [IDX_W-1:0]                      issue_ff, issue_in;

   logic [lsts_pkg::SLOT_OUT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic                                  pend_idle_ff, pend_idle_in;
   logic signed [SOW-1:0]                 pend_slack_ff, pend_slack_in;
   logic [lsts_pkg::TIME_OUT_W-1:0]       pend_time_ff, pend_time_in;
   logic                                  pend_done_ff, pend_done_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [lsts_pkg::SLOT_OUT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                                  rsp_idle_ff, rsp_idle_in;
   logic signed [SOW-1:0]                 rsp_slack_ff, rsp_slack_in;
   logic [lsts_pkg::TIME_OUT_W-1:0]       rsp_time_ff, rsp_time_in;
   logic                                  rsp_done_ff, rsp_done_in;

   logic                                  mem_we;
   logic [IDX_W-1:0]                      mem_waddr;
   lsts_pkg::job_entry_type               mem_wdata;
   lsts_pkg::job_entry_type               mem_rdata;
   lsts_pkg::scan_ctl_type                scan_ctl;

   logic                                  found;
   logic [IDX_W-1:0]                      pick;
   logic signed [SW-1:0]                  best_slack;
   lsts_pkg::job_entry_type               best_job;
   logic signed [SOW-1:0]                 slack_sat;
   logic                                  table_full;
   logic                                  scan_last;

   lsts_job_mem #(
      .DEPTH (MAX_JOBS),
      .IDX_W (IDX_W)
   ) u_job_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (issue_ff),
      .rdata (mem_rdata)
   );

   lsts_min_tracker #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .SW        (SW)
   ) u_min_tracker (
      .clock      (clock),
      .reset      (reset),
      .scan_ctl   (scan_ctl),
      .scan_idx   (issue_ff),
      .time_now   (time_ff),
      .rd_job     (mem_rdata),
      .found      (found),
      .pick       (pick),
      .best_slack (best_slack),
      .best_job   (best_job)
   );

   assign table_full = (job_count_ff == CNT_W'(MAX_JOBS));
   assign scan_last  = ((CNT_W'(issue_ff) + CNT_W'(1)) == job_count_ff);

   // Reported slack saturates to the output range.
   always_comb begin
      if (best_slack > SLACK_HI) begin
         slack_sat = SOW'(SLACK_HI);
      end else if (best_slack < SLACK_LO) begin
         slack_sat = SOW'(SLACK_LO);
      end else begin
         slack_sat = best_slack[SOW-1:0];
      end
   end

   // Sequencer: next state, table writes and result staging.
   always_comb begin
      state_in      = state_ff;
      job_count_in  = job_count_ff;
      time_in       = time_ff;
      issue_in      = issue_ff;
      pend_slot_in  = pend_slot_ff;
      pend_idle_in  = pend_idle_ff;
      pend_slack_in = pend_slack_ff;
      pend_time_in  = pend_time_ff;
      pend_done_in  = pend_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_idle_in   = rsp_idle_ff;
      rsp_slack_in  = rsp_slack_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_done_in   = rsp_done_ff;
      mem_we        = 1'b0;
      mem_waddr     = job_count_ff[IDX_W-1:0];
      mem_wdata     = '{release_time: req_ch.release_time,
                        deadline:     req_ch.deadline,
                        remaining:    req_ch.exec_time};
      scan_ctl      = '0;
      req_ch.ready  = (state_ff == lsts_pkg::S_IDLE);

      unique case (state_ff)
         lsts_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               pend_time_in  = lsts_pkg::TIME_OUT_W'(time_ff);
               pend_slack_in = '0;
               pend_done_in  = 1'b0;
               pend_slot_in  = '0;
               pend_idle_in  = 1'b1;
               if (req_ch.opcode == lsts_pkg::OP_LOAD) begin
                  // A load fills the next free slot unless the table is full.
                  if (!table_full) begin
                     mem_we       = 1'b1;
                     pend_slot_in = lsts_pkg::SLOT_OUT_W'(job_count_ff[IDX_W-1:0]);
                     pend_idle_in = 1'b0;
                     job_count_in = job_count_ff + CNT_W'(1);
                  end
                  state_in = lsts_pkg::S_RESULT;
               end else begin
                  // A tick scans every loaded slot from slot zero.
                  scan_ctl.start = 1'b1;
                  issue_in       = '0;
                  state_in       = (job_count_ff == '0) ? lsts_pkg::S_FINISH
                                                        : lsts_pkg::S_SCAN;
               end
            end
         end
         lsts_pkg::S_SCAN: begin
            scan_ctl.valid = 1'b1;
            if (scan_last) begin
               state_in = lsts_pkg::S_DRAIN;
            end else begin
               issue_in = issue_ff + IDX_W'(1);
            end
         end
         lsts_pkg::S_DRAIN: begin
            state_in = lsts_pkg::S_FINISH;
         end
         lsts_pkg::S_FINISH: begin
            // Charge one tick to the chosen job and advance time unless it is at its maximum.
            if (found) begin
               mem_we        = 1'b1;
               mem_waddr     = pick;
               mem_wdata     = '{release_time: best_job.release_time,
                                 deadline:     best_job.deadline,
                                 remaining:    best_job.remaining - lsts_pkg::FIELD_W'(1)};
               pend_slot_in  = lsts_pkg::SLOT_OUT_W'(pick);
               pend_idle_in  = 1'b0;
               pend_slack_in = slack_sat;
               pend_done_in  = (best_job.remaining == lsts_pkg::FIELD_W'(1));
            end
            if (time_ff != TIME_MAX) begin
               time_in = time_ff + TIME_BITS'(1);
            end
            state_in = lsts_pkg::S_RESULT;
         end
         lsts_pkg::S_RESULT: begin
            // Hand the staged result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = pend_slot_ff;
               rsp_idle_in  = pend_idle_ff;
               rsp_slack_in = pend_slack_ff;
               rsp_time_in  = pend_time_ff;
               rsp_done_in  = pend_done_ff;
               state_in     = lsts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lsts_pkg::S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lsts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_count_ff <= job_count_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      issue_ff      <= issue_in;
      pend_slot_ff  <= pend_slot_in;
      pend_idle_ff  <= pend_idle_in;
      pend_slack_ff <= pend_slack_in;
      pend_time_ff  <= pend_time_in;
      pend_done_ff  <= pend_done_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_idle_ff   <= rsp_idle_in;
      rsp_slack_ff  <= rsp_slack_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.slot         = rsp_slot_ff;
   assign rsp_ch.idle         = rsp_idle_ff;
   assign rsp_ch.slack        = rsp_slack_ff;
   assign rsp_ch.current_time = rsp_time_ff;
   assign rsp_ch.job_done     = rsp_done_ff;

   // The job count never passes the table size.
   `LSTS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, job_count_ff <= CNT_W'(MAX_JOBS))
   // A scan only runs over a table that holds at least one job.
   `LSTS_ASSERT_NOW(a_scan_nonempty, clock, reset, state_ff == lsts_pkg::S_SCAN, job_count_ff != '0)
   // An idle result carries neither slack nor completion.
   `LSTS_ASSERT_NOW(a_idle_clean, clock, reset, rsp_valid_ff && rsp_idle_ff, rsp_slack_ff == '0 && !rsp_done_ff)
   // Time never moves backward.
   `LSTS_ASSERT_NEXT(a_time_mono, clock, reset, 1'b1, time_ff >= $past(time_ff))

endmodule

`default_nettype wire
